// ----- src/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Payload types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage
`default_nettype wire

// ----- src/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the working variables and the 16-word schedule window; one round
// per cycle while round_en is high, loaded from the hash words on load.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_round import sha256_pkg::*; (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [31:0] hash_in [8],
   input  wire logic        round_en,
   input  wire logic [5:0]  round_idx,
   input  wire logic [31:0] msg_word,
   output logic      [31:0] vars_out [8]
);

   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_new;
   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      if (round_idx[5:4] == 2'd0) begin
         w_new = msg_word;
      end else begin
         w_new = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);
      end
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[round_idx] + w_new;
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
         ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         v_ff <= hash_in;
      end else if (round_en) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end
   end

   assign vars_out = v_ff;

endmodule
`default_nettype wire

// ----- src/sha256_stream_hash.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Byte-stream SHA-256 with a 64-byte block memory and one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one request per byte (data_byte, byte_present,
//   message_end). A request without a byte but with message_end closes the
//   message, so an empty message can be hashed.
//   rsp_ channel: eight digest words per message, word 0 first, digest_last
//   on word 7.
// Timing:
//   A byte that does not fill the block leaves the block ready for the next request. The 64th byte of a
//   block starts a compression: a load step, 64 rounds (the first 16 take
//   their message word from the block memory) and a hash update step; no
//   request is taken until it is done. A closing request writes the padding
//   one byte per cycle, runs one or two compressions and then offers eight
//   words, one per cycle when the receiver takes them.
// Reset clears control state and reloads the initial hash values. The block
// memory needs no clearing. A stalled receiver holds the current word and
// the block takes no request until all eight words are gone.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hash import sha256_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RUN  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [31:0] mem [16];
   logic [31:0] rd_ff;
   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        closing_ff, closing_in;
   logic        final_ff, final_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [31:0] hash_ff [8];
   logic [31:0] vars [8];
   logic [63:0] bits;
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_byte;
   logic        accept;
   logic        round_en;
   logic        load;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign bits      = {total_ff, 3'b000};
   assign load      = (state_ff == ST_LOAD);
   assign round_en  = (state_ff == ST_RUN) && !rnd_ff[6];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff;
      wr_byte = req_data.data_byte;
      if (state_ff == ST_IDLE) begin
         wr_en = accept && req_data.byte_present;
      end else if (state_ff == ST_PAD) begin
         wr_en = 1'b1;
         if (!final_ff) begin
            wr_byte = PAD_BYTE;
         end else if (fill_ff >= 6'd56 && !closing_ff) begin
            wr_byte = bits[8 * (63 - fill_ff) +: 8];
         end else begin
            wr_byte = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[5:2]][8 * (3 - wr_addr[1:0]) +: 8] <= wr_byte;
      end
      rd_ff <= mem[rnd_in[3:0]];
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      total_in   = total_ff;
      rnd_in     = rnd_ff;
      closing_in = closing_ff;
      final_in   = final_ff;
      oidx_in    = oidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               closing_in = req_data.message_end;
               final_in   = 1'b0;
               if (req_data.byte_present) begin
                  fill_in = fill_ff + 6'd1;
                  if (total_ff != '1) begin
                     total_in = total_ff + 61'd1;
                  end
               end
               if (req_data.byte_present && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_data.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            fill_in  = fill_ff + 6'd1;
            final_in = 1'b1;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
            end else if (fill_ff == 6'd55) begin
               closing_in = 1'b0;
            end
         end
         ST_LOAD: begin
            rnd_in   = 7'd0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (closing_ff) begin
               state_in = ST_PAD;
            end else if (final_ff) begin
               oidx_in  = 3'd0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  total_in = '0;
                  fill_in  = '0;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         total_ff   <= '0;
         rnd_ff     <= '0;
         closing_ff <= 1'b0;
         final_ff   <= 1'b0;
         oidx_ff    <= '0;
         hash_ff    <= INIT_HASH;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         total_ff   <= total_in;
         rnd_ff     <= rnd_in;
         closing_ff <= closing_in;
         final_ff   <= final_in;
         oidx_ff    <= oidx_in;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + vars[i];
            end
         end else if (state_ff == ST_OUT && rsp_ready && oidx_ff == 3'd7) begin
            hash_ff <= INIT_HASH;
         end
      end
   end

   sha256_round u_round (
      .clock     (clock),
      .load      (load),
      .hash_in   (hash_ff),
      .round_en  (round_en),
      .round_idx (rnd_ff[5:0]),
      .msg_word  (rd_ff),
      .vars_out  (vars)
   );

   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_data.digest_word = hash_ff[oidx_ff];
   assign rsp_data.word_index  = oidx_ff;
   assign rsp_data.digest_last = (oidx_ff == 3'd7);

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Streams byte messages into the hash block under random gaps and stalls,
// computes each digest in a local SHA-256 model and checks every word.
// ----------------------------------------------------------------------------
module tb_top;
   import sha256_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_words[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   bit      stimulus_done = 1'b0;
   int      phase_pct[4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{23, 23}};

   logic [31:0] digest_state[8];
   logic [7:0]  block_bytes[64];
   int          fill_level;
   logic [60:0] byte_count;

   sha256_stream_hash DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress_chunk();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      {a, b, c, d, e, f, g, h} = {digest_state[0], digest_state[1], digest_state[2],
         digest_state[3], digest_state[4], digest_state[5], digest_state[6], digest_state[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      digest_state[0] += a; digest_state[1] += b; digest_state[2] += c;
      digest_state[3] += d; digest_state[4] += e; digest_state[5] += f;
      digest_state[6] += g; digest_state[7] += h;
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) digest_state[i] = INIT_HASH[i];
      fill_level = 0;
      byte_count = '0;
   endtask

   task automatic hash_request(req_type r);
      logic [63:0] bit_len;
      rsp_type     word;
      if (r.byte_present) begin
         block_bytes[fill_level] = r.data_byte;
         fill_level++;
         if (byte_count != '1) byte_count++;
         if (fill_level == 64) begin
            compress_chunk();
            fill_level = 0;
         end
      end
      if (!r.message_end) return;
      bit_len = {byte_count, 3'b000};
      block_bytes[fill_level] = PAD_BYTE;
      fill_level++;
      if (fill_level > 56) begin
         for (int i = fill_level; i < 64; i++) block_bytes[i] = 8'h00;
         compress_chunk();
         fill_level = 0;
      end
      for (int i = fill_level; i < 56; i++) block_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
      compress_chunk();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = digest_state[i];
         word.word_index = i[2:0];
         word.digest_last = (i == 7);
         expected_words.push_back(word);
      end
      restart_message();
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   task automatic queue_message(int len, bit fixed, logic [7:0] value, bit close_empty);
      req_type r;
      for (int i = 0; i < len; i++) begin
         r.data_byte = fixed ? value : 8'($urandom);
         r.byte_present = 1'b1;
         r.message_end = !close_empty && (i == len - 1);
         pending_requests.push_back(r);
      end
      if (close_empty || len == 0) begin
         r.data_byte = 8'($urandom);
         r.byte_present = 1'b0;
         r.message_end = 1'b1;
         pending_requests.push_back(r);
      end
   endtask

   task automatic queue_noise(int len);
      req_type r;
      for (int i = 0; i < len; i++) begin
         r.data_byte = 8'($urandom);
         r.byte_present = 1'b0;
         r.message_end = 1'b0;
         pending_requests.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) hash_request(req_data);
         if ((!req_valid || req_ready) && pending_requests.size() > 0
             && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.digest_word, '0);
            end else begin
               rsp_type want;
               want = expected_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index !== want.word_index)
                  report_mismatch("word_index", 32'(rsp_data.word_index),
                     32'(want.word_index));
               if (rsp_data.digest_last !== want.digest_last)
                  report_mismatch("digest_last", 32'(rsp_data.digest_last),
                     32'(want.digest_last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      restart_message();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      queue_message(0, 1'b0, 8'h00, 1'b1);
      queue_message(1, 1'b1, 8'h00, 1'b0);
      queue_message(1, 1'b1, 8'hff, 1'b1);
      queue_message(3, 1'b1, 8'h61, 1'b0);
      queue_noise(2);
      queue_message(2, 1'b1, 8'haa, 1'b1);
      queue_message(2, 1'b1, 8'h55, 1'b0);
      queue_message(1, 1'b0, 8'h00, 1'b0);
      queue_message(55, 1'b0, 8'h00, 1'b0);
      queue_message(56, 1'b0, 8'h00, 1'b0);
      queue_message(63, 1'b0, 8'h00, 1'b1);
      queue_message(64, 1'b0, 8'h00, 1'b0);
      queue_message(64, 1'b0, 8'h00, 1'b1);

      for (int p = 0; p < 4; p++) begin
         int budget;
         wait (pending_requests.size() == 0 && expected_words.size() == 0);
         send_idle_pct = phase_pct[p][0];
         stall_pct = phase_pct[p][1];
         budget = (p == 0) ? 0 : 37;
         while (budget > 0) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            if (len > budget) len = budget;
            if ($urandom_range(7) == 0) queue_noise($urandom_range(3));
            queue_message(len, 1'b0, 8'h00, $urandom_range(3) == 0);
            budget -= len + 1;
         end
      end
      wait (pending_requests.size() == 0 && !req_valid && expected_words.size() == 0);
      stimulus_done = 1'b1;
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
